@@ sv/bsst_pkg.sv @@
package bsst_pkg;

	localparam int unsigned MAX_ENTRIES = 64;
	localparam int unsigned VAL_W = 32;
	localparam int unsigned CNT_W = 7;
	localparam int unsigned POS_W = 6;
	localparam logic [VAL_W-1:0] SPAN_CAP = 32'h7FFF_FFFF;
	localparam logic [VAL_W-1:0] SIGN_BIT = 32'h8000_0000;

	localparam logic [1:0] ACT_ADD  = 2'd0;
	localparam logic [1:0] ACT_EDIT = 2'd1;

	localparam logic [1:0] ST_OK       = 2'd0;
	localparam logic [1:0] ST_FULL     = 2'd1;
	localparam logic [1:0] ST_BAD_POS  = 2'd2;
	localparam logic [1:0] ST_TOO_FEW  = 2'd3;

	typedef enum logic [3:0] {
		S_IDLE,
		S_VRD,
		S_RM_RD,
		S_RM_CHK,
		S_INS_RD,
		S_INS_CHK,
		S_SC_BEGIN,
		S_SC_RD,
		S_SC_CHK,
		S_DONE
	} bsst_state_t;

	// Access to the insertion-order store, addresses at count width.
	typedef struct packed {
		logic             we;
		logic [CNT_W-1:0] waddr;
		logic [VAL_W-1:0] wdata;
		logic [CNT_W-1:0] raddr;
	} bsst_idx_req_t;

	function automatic logic [VAL_W-1:0] order_key(input logic [VAL_W-1:0] v);
		return v ^ SIGN_BIT;
	endfunction

endpackage

@@ sv/bsst_index_store.sv @@
module bsst_index_store
	import bsst_pkg::*;
(
	input  logic             clk,
	input  bsst_idx_req_t    req,
	output logic [VAL_W-1:0] rdata
);

	localparam int unsigned AW = (MAX_ENTRIES > 1) ? $clog2(MAX_ENTRIES) : 1;

	logic [VAL_W-1:0] mem [MAX_ENTRIES];

	// values in insertion order; one write and one registered read a cycle
	always_ff @(posedge clk) begin
		if (req.we) begin
			mem[AW'(req.waddr)] <= req.wdata;
		end
		rdata <= mem[AW'(req.raddr)];
	end

endmodule

@@ sv/bounded_set_span_tracker.sv @@
// Channel   | Ports                                   | Handshake
// ----------+-----------------------------------------+-------------------------------
// item in   | action, value, position                 | taken when start & !busy
// result    | status, spans_valid, shortest_span,     | done high one cycle, no stall
//           | longest_span, stored_count              |
// config    | capacity_wdata                          | written when capacity_we
//
// One item at a time; busy rises after the accept edge and stays high through the
// result strobe. The sorted store is one memory with a registered read. An add
// runs an insert pass walking down from the end; an edit first reads the old value
// from the insertion-order store and runs a remove pass over every entry before it.
// A scan setup step and the span scan (skipped below two values) follow, then the
// result strobe. Reset clears count and control; memories need no clearing pass.
// The result receiver cannot stall.
module bounded_set_span_tracker
	import bsst_pkg::*;
(
	input  logic             clk,
	input  logic             arst_n,
	input  logic             start,
	output logic             busy,
	input  logic [1:0]       action,
	input  logic [VAL_W-1:0] value,
	input  logic [POS_W-1:0] position,
	input  logic             capacity_we,
	input  logic [CNT_W-1:0] capacity_wdata,
	output logic             done,
	output logic [1:0]       status,
	output logic             spans_valid,
	output logic [30:0]      shortest_span,
	output logic [VAL_W-1:0] longest_span,
	output logic [CNT_W-1:0] stored_count
);

	localparam int unsigned AW = (MAX_ENTRIES > 1) ? $clog2(MAX_ENTRIES) : 1;

	bsst_state_t      state_q, state_d;
	logic [CNT_W-1:0] capacity_q, count_q, limit;
	logic [1:0]       act_q, status_q;
	logic [VAL_W-1:0] val_q, old_q, prev_q, first_q, min_q;
	logic [CNT_W-1:0] pos_q, k_q;
	logic             found_q;

	bsst_idx_req_t    idx_req;
	logic [VAL_W-1:0] idx_rdata;

	logic [VAL_W-1:0] sorted_mem [MAX_ENTRIES];
	logic [VAL_W-1:0] s_rdata_s1;
	logic             s_we;
	logic [CNT_W-1:0] s_waddr, s_raddr;
	logic [VAL_W-1:0] s_wdata, gap;
	logic             accept, last_k, ins_move;

	bsst_index_store u_index (
		.clk   (clk),
		.req   (idx_req),
		.rdata (idx_rdata)
	);

	// capacity saturates at the store depth
	assign limit  = (int'(capacity_q) > int'(MAX_ENTRIES)) ? CNT_W'(MAX_ENTRIES) : capacity_q;
	assign accept = start && (state_q == S_IDLE);
	assign last_k = (k_q + 7'd1 == count_q);
	assign gap    = s_rdata_s1 - prev_q;
	// insert walks down while the entry below orders above the new value
	assign ins_move = order_key(s_rdata_s1) > order_key(val_q);

	always_ff @(posedge clk) begin
		if (s_we) begin
			sorted_mem[AW'(s_waddr)] <= s_wdata;
		end
		s_rdata_s1 <= sorted_mem[AW'(s_raddr)];
	end

	// next state
	always_comb begin
		state_d = state_q;
		unique case (state_q)
			S_IDLE: begin
				if (accept) begin
					if (action == ACT_ADD && count_q < limit) begin
						state_d = S_INS_RD;
					end else if (action == ACT_EDIT && {1'b0, position} < count_q) begin
						state_d = S_VRD;
					end else begin
						state_d = S_SC_BEGIN;
					end
				end
			end
			S_VRD:      state_d = S_RM_RD;
			S_RM_RD:    state_d = S_RM_CHK;
			S_RM_CHK:   state_d = last_k ? S_INS_RD : S_RM_RD;
			S_INS_RD:   state_d = (k_q == '0) ? S_SC_BEGIN : S_INS_CHK;
			S_INS_CHK:  state_d = ins_move ? S_INS_RD : S_SC_BEGIN;
			S_SC_BEGIN: state_d = (count_q < 7'd2) ? S_DONE : S_SC_RD;
			S_SC_RD:    state_d = S_SC_CHK;
			S_SC_CHK:   state_d = last_k ? S_DONE : S_SC_RD;
			S_DONE:     state_d = S_IDLE;
			default:    state_d = S_IDLE;
		endcase
	end

	// memory controls
	always_comb begin
		s_we          = 1'b0;
		s_waddr       = k_q;
		s_wdata       = val_q;
		s_raddr       = k_q;
		idx_req.we    = 1'b0;
		idx_req.waddr = count_q;
		idx_req.wdata = value;
		idx_req.raddr = {1'b0, position};
		unique case (state_q)
			S_IDLE: begin
				// append to the insertion-order store right away
				idx_req.we = accept && action == ACT_ADD && count_q < limit;
			end
			S_VRD: begin
				idx_req.we    = 1'b1;
				idx_req.waddr = pos_q;
				idx_req.wdata = val_q;
			end
			S_RM_CHK: begin
				// close the gap left by the old value
				s_we    = found_q;
				s_waddr = k_q - 7'd1;
				s_wdata = s_rdata_s1;
			end
			S_INS_RD: begin
				s_we    = (k_q == '0);
				s_raddr = k_q - 7'd1;
			end
			S_INS_CHK: begin
				s_we    = 1'b1;
				s_wdata = ins_move ? s_rdata_s1 : val_q;
			end
			default: ;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q    <= S_IDLE;
			count_q    <= '0;
			capacity_q <= 7'd64;
		end else begin
			state_q <= state_d;
			if (capacity_we) begin
				capacity_q <= capacity_wdata;
			end
			if (state_q == S_INS_RD && k_q == '0 && act_q == ACT_ADD) begin
				count_q <= count_q + 7'd1;
			end else if (state_q == S_INS_CHK && !ins_move && act_q == ACT_ADD) begin
				count_q <= count_q + 7'd1;
			end
		end
	end

	always_ff @(posedge clk) begin
		unique case (state_q)
			S_IDLE: begin
				act_q <= action;
				val_q <= value;
				pos_q <= {1'b0, position};
				k_q   <= count_q;
				if (action == ACT_ADD) begin
					status_q <= (count_q < limit) ? ST_OK : ST_FULL;
				end else if (action == ACT_EDIT) begin
					status_q <= ({1'b0, position} < count_q) ? ST_OK : ST_BAD_POS;
				end else begin
					status_q <= (count_q < 7'd2) ? ST_TOO_FEW : ST_OK;
				end
			end
			S_VRD: begin
				old_q   <= idx_rdata;
				k_q     <= '0;
				found_q <= 1'b0;
			end
			S_RM_CHK: begin
				if (!found_q && s_rdata_s1 == old_q) begin
					found_q <= 1'b1;
				end
				k_q <= last_k ? count_q - 7'd1 : k_q + 7'd1;
			end
			S_INS_CHK: begin
				if (ins_move) begin
					k_q <= k_q - 7'd1;
				end
			end
			S_SC_BEGIN: begin
				k_q   <= '0;
				min_q <= SPAN_CAP;
			end
			S_SC_CHK: begin
				if (k_q == '0) begin
					first_q <= s_rdata_s1;
				end else if (gap < min_q) begin
					min_q <= gap;
				end
				prev_q <= s_rdata_s1;
				k_q    <= k_q + 7'd1;
			end
			default: ;
		endcase
	end

	// result outputs
	always_comb begin
		busy          = (state_q != S_IDLE);
		done          = (state_q == S_DONE);
		status        = status_q;
		stored_count  = count_q;
		spans_valid   = (count_q >= 7'd2);
		shortest_span = spans_valid ? min_q[30:0] : '0;
		longest_span  = spans_valid ? (prev_q - first_q) : '0;
	end

	a_done_to_idle: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == S_DONE) |=> (state_q == S_IDLE))
		else $error("result strobe not followed by idle");
	a_count_bound: assert property (@(posedge clk) disable iff (!arst_n)
		int'(count_q) <= int'(MAX_ENTRIES))
		else $error("count beyond store depth");
	a_accept_busy: assert property (@(posedge clk) disable iff (!arst_n)
		(start && !busy) |=> busy)
		else $error("accepted item did not raise busy");
	a_count_step: assert property (@(posedge clk) disable iff (!arst_n)
		(count_q != $past(count_q)) |-> (count_q == $past(count_q) + 7'd1))
		else $error("count changed by other than one");

endmodule
